[src/sktbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sktbl_pkg;

  // Operation codes carried on the command field.
  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_VALIDATE = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_CLEANUP  = 2'd3
  } cmd_e;

  // Result codes carried on the status field.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_EXPIRED    = 3'd4
  } status_e;

  // Reset value of the slots-in-use register.
  localparam logic [4:0] SLOTS_IN_USE_RST = 5'd16;

endpackage

`default_nettype wire

[src/session_key_table_with_expiry.sv]
`timescale 1ns / 1ps
`default_nettype none

// Session key table with lifetime expiry. Every input transaction carries one
// command (create, validate, delete or clean up expired slots) and produces
// exactly one result transaction with a status, the slot touched, the number of
// live slots afterwards and, for clean-up, the number of slots removed. Keys,
// creation times and lifetimes live in a single synchronous memory with one
// read port and one write port; the per-slot valid bits and the live count are
// flip-flops cleared by reset, so the block is usable right after reset. A
// command walks the slots one per cycle, from slot zero up to the smaller of
// the slots-in-use register and SLOTS, and stops at the first slot that
// settles it. An item is accepted, then visits its slots, each slot's word
// arriving from the memory read port before it is checked, and then its
// result moves into the output register. A command that visits at least one
// slot and reaches the end of the scan without being settled, as every
// clean-up does, still has to see that the scan is over once the last
// slot is checked. A create on a full table and a validate or delete with
// a wrong key length skip the scan and go straight to the result. Items
// are processed one at a time; the next item is accepted as soon as the
// result has moved to the output register, even while that result still
// waits to be taken. The slots-in-use register may only be written while no
// transaction is in flight; it is always ready.
module session_key_table_with_expiry
  import sktbl_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int KEY_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,
  // Command channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [63:0] key_i,
  input  wire logic [7:0]  key_length_i,
  input  wire logic [31:0] lifetime_i,
  input  wire logic [31:0] current_time_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [3:0]       slot_index_o,
  output logic [4:0]       live_count_o,
  output logic [4:0]       cleared_count_o
);

  localparam int KEY_BITS = 8 * KEY_BYTES;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int WORD_W   = KEY_BITS + 64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [31:0]          now_q, now_d;
  logic [31:0]          life_q, life_d;
  logic [4:0]           slots_in_use_q;
  logic [CNT_W-1:0]     limit;

  logic [CNT_W-1:0]     issue_q, issue_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;
  logic [SLOTS-1:0]     slot_valid_q, slot_valid_d;
  logic [CNT_W-1:0]     live_q, live_d;
  logic [CNT_W-1:0]     clr_q, clr_d;

  status_e              res_status_q, res_status_d;
  logic [3:0]           res_idx_q, res_idx_d;

  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_status_q, out_status_d;
  logic [3:0]           out_idx_q, out_idx_d;
  logic [4:0]           out_live_q, out_live_d;
  logic [4:0]           out_clr_q, out_clr_d;

  // Slot store: {lifetime, creation time, key} per slot.
  logic [WORD_W-1:0]    slot_mem [SLOTS];
  logic [WORD_W-1:0]    mem_rd_q;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_ra;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [WORD_W-1:0]    mem_wd;

  logic [KEY_BITS-1:0]  ent_key;
  logic [31:0]          ent_created;
  logic [31:0]          ent_life;
  logic [31:0]          ent_age;
  logic                 ent_valid;
  logic                 ent_hit;
  logic                 ent_expired;

  logic                 in_hs;
  logic                 out_hs;

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign in_hs           = in_valid_i & in_ready_o;
  assign out_hs          = out_valid_q & out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_index_o    = out_idx_q;
  assign live_count_o    = out_live_q;
  assign cleared_count_o = out_clr_q;

  // Scans never go past the configured number of slots or the table size.
  always_comb begin
    if (int'(slots_in_use_q) > SLOTS) begin
      limit = CNT_W'(SLOTS);
    end else begin
      limit = CNT_W'(slots_in_use_q);
    end
  end

  // Fields of the slot whose read data arrived this cycle.
  assign ent_key     = mem_rd_q[KEY_BITS-1:0];
  assign ent_created = mem_rd_q[KEY_BITS+31:KEY_BITS];
  assign ent_life    = mem_rd_q[WORD_W-1:KEY_BITS+32];
  assign ent_age     = now_q - ent_created;
  assign ent_valid   = slot_valid_q[chk_idx_q];
  assign ent_hit     = ent_valid && (ent_key == key_q);
  assign ent_expired = ent_age > ent_life;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    now_d        = now_q;
    life_d       = life_q;
    issue_d      = issue_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    slot_valid_d = slot_valid_q;
    live_d       = live_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_live_d   = out_live_q;
    out_clr_d    = out_clr_q;
    mem_re       = 1'b0;
    mem_ra       = issue_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_wa       = chk_idx_q;
    mem_wd       = {life_q, now_q, key_q};

    if (out_hs) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          cmd_d        = cmd_e'(command_i);
          key_d        = key_i[KEY_BITS-1:0];
          now_d        = current_time_i;
          life_d       = lifetime_i;
          issue_d      = '0;
          chk_vld_d    = 1'b0;
          clr_d        = '0;
          res_idx_d    = '0;
          res_status_d = ST_OK;
          if ((cmd_e'(command_i) == CMD_CREATE) && (live_q >= limit)) begin
            res_status_d = ST_TABLE_FULL;
            state_d      = S_DONE;
          end else if (((cmd_e'(command_i) == CMD_VALIDATE) ||
                        (cmd_e'(command_i) == CMD_DELETE)) &&
                       (key_length_i != 8'(KEY_BYTES))) begin
            res_status_d = ST_BAD_LENGTH;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the read of the next slot while the previous one is checked.
        if (issue_q < limit) begin
          mem_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = issue_q[IDX_W-1:0];
          issue_d   = issue_q + 1'b1;
        end else begin
          chk_vld_d = 1'b0;
        end

        if (chk_vld_q) begin
          case (cmd_q)
            CMD_CREATE: begin
              if (!ent_valid) begin
                mem_we                  = 1'b1;
                slot_valid_d[chk_idx_q] = 1'b1;
                live_d                  = live_q + 1'b1;
                res_idx_d               = 4'(chk_idx_q);
                res_status_d            = ST_OK;
                state_d                 = S_DONE;
              end
            end
            CMD_VALIDATE: begin
              if (ent_hit) begin
                res_idx_d = 4'(chk_idx_q);
                state_d   = S_DONE;
                if (ent_expired) begin
                  slot_valid_d[chk_idx_q] = 1'b0;
                  if (live_q != '0) begin
                    live_d = live_q - 1'b1;
                  end
                  res_status_d = ST_EXPIRED;
                end
              end
            end
            CMD_DELETE: begin
              if (ent_hit) begin
                slot_valid_d[chk_idx_q] = 1'b0;
                if (live_q != '0) begin
                  live_d = live_q - 1'b1;
                end
                res_idx_d = 4'(chk_idx_q);
                state_d   = S_DONE;
              end
            end
            CMD_CLEANUP: begin
              if (ent_valid && ent_expired) begin
                slot_valid_d[chk_idx_q] = 1'b0;
                if (live_q != '0) begin
                  live_d = live_q - 1'b1;
                end
                clr_d = clr_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (issue_q >= limit) begin
          // Every slot below the limit was visited without settling the item.
          case (cmd_q)
            CMD_CREATE:   res_status_d = ST_TABLE_FULL;
            CMD_VALIDATE: res_status_d = ST_NOT_FOUND;
            CMD_DELETE:   res_status_d = ST_NOT_FOUND;
            default:      res_status_d = ST_OK;
          endcase
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = res_idx_q;
          out_live_d   = 5'(live_q);
          out_clr_d    = 5'(clr_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      slots_in_use_q <= SLOTS_IN_USE_RST;
      issue_q        <= '0;
      chk_vld_q      <= 1'b0;
      slot_valid_q   <= '0;
      live_q         <= '0;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slots_in_use_q <= cfg_data_i;
      end
      issue_q      <= issue_d;
      chk_vld_q    <= chk_vld_d;
      slot_valid_q <= slot_valid_d;
      live_q       <= live_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    now_q        <= now_d;
    life_q       <= life_d;
    chk_idx_q    <= chk_idx_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_live_q   <= out_live_d;
    out_clr_q    <= out_clr_d;
  end

  // The slot memory is only written when a create claims a slot, and that
  // ends the scan, so a read never meets a pending write to the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= slot_mem[mem_ra];
    end
  end

`ifndef SYNTHESIS
  a_live_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_valid_q) == int'(live_q))
    else $error("live count differs from the number of valid slots");

  a_live_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(SLOTS))
    else $error("live count exceeds the table size");

  a_scan_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && chk_vld_q) |-> (CNT_W'(chk_idx_q) < limit))
    else $error("scan checked a slot beyond the limit");

  a_create_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_we) |=> slot_valid_q[$past(chk_idx_q)])
    else $error("created slot was not marked valid");
`endif

endmodule

`default_nettype wire

[sim/tb_session_key_table_with_expiry.sv]
`timescale 1ns / 1ps

module tb_session_key_table_with_expiry;
  import sktbl_pkg::*;

  localparam int SLOTS     = 16;
  localparam int KEY_BYTES = 8;
  localparam int POOL_KEYS = 8;
  // Cycles to let pass after the last result before a register write or the
  // final verdict. An item visits at most SLOTS slots.
  localparam int QUIET_CYCLES = SLOTS + 8;
  localparam int END_CYCLES   = 2 * SLOTS + 8;
  localparam int RESULT_HOLD  = 400;

  localparam logic [63:0] KEY_MASK = (KEY_BYTES >= 8) ? {64{1'b1}} :
                                     ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  // One predicted result transaction.
  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    logic [4:0] live;
    logic [4:0] cleared;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [63:0] key_i;
  logic [7:0]  key_length_i;
  logic [31:0] lifetime_i;
  logic [31:0] current_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [3:0]  slot_index_o;
  logic [4:0]  live_count_o;
  logic [4:0]  cleared_count_o;

  session_key_table_with_expiry #(
    .SLOTS    (SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_i          (key_i),
    .key_length_i   (key_length_i),
    .lifetime_i     (lifetime_i),
    .current_time_i (current_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .live_count_o   (live_count_o),
    .cleared_count_o(cleared_count_o)
  );

  // Shadow copy of the session table. The predictor below updates it once
  // for every command transaction, at the edge where the block accepts it.
  logic        tbl_valid [SLOTS];
  logic [63:0] tbl_key   [SLOTS];
  logic [31:0] tbl_born  [SLOTS];
  logic [31:0] tbl_life  [SLOTS];
  int unsigned tbl_live;
  logic [4:0]  tbl_limit_reg;

  // Results still owed by the block, oldest first.
  table_result_t pending_outcomes[$];

  int unsigned mismatch_count;
  // While set, both sides insert random idle bursts. It is cleared for the
  // last part of the run.
  bit          idle_en;
  // Set by a test to make the result side hold off for that many cycles.
  int unsigned result_hold_cycles;

  // Time base and key pool for the random traffic. Keys come from a small
  // pool so that validate and delete actually find their sessions.
  logic [31:0] wall_time;
  logic [63:0] key_pool [POOL_KEYS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The register value saturates at the table size.
  function automatic int unsigned scan_limit();
    return (tbl_limit_reg > SLOTS) ? SLOTS : int'(tbl_limit_reg);
  endfunction

  // The age is taken modulo 2^32, so a session created just before the
  // time counter wraps still ages correctly after the wrap.
  function automatic logic slot_expired(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - tbl_born[i];
    return age > tbl_life[i];
  endfunction

  function automatic void drop_slot(int i);
    tbl_valid[i] = 1'b0;
    if (tbl_live > 0) tbl_live--;
  endfunction

  function automatic void reset_table_model();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_born[i]  = '0;
      tbl_life[i]  = '0;
    end
    tbl_live      = 0;
    tbl_limit_reg = SLOTS_IN_USE_RST;
  endfunction

  // Works out the result of one command and applies it to the shadow table.
  function automatic table_result_t table_outcome(cmd_e cmd, logic [63:0] key,
                                                  logic [7:0] klen, logic [31:0] life,
                                                  logic [31:0] now);
    table_result_t res;
    int unsigned   limit;
    int            hit;
    logic          placed;
    logic [63:0]   stored;
    res.status  = ST_OK;
    res.slot    = '0;
    res.cleared = '0;
    limit  = scan_limit();
    stored = key & KEY_MASK;
    hit    = -1;
    placed = 1'b0;
    case (cmd)
      CMD_CREATE: begin
        // The key length is not checked on create. Slots above a lowered
        // limit still count toward the live total, so the table may report
        // full while low slots are free.
        res.status = ST_TABLE_FULL;
        if (tbl_live < limit) begin
          for (int i = 0; i < limit; i++) begin
            if (!placed && !tbl_valid[i]) begin
              placed       = 1'b1;
              tbl_valid[i] = 1'b1;
              tbl_key[i]   = stored;
              tbl_born[i]  = now;
              tbl_life[i]  = life;
              tbl_live++;
              res.status   = ST_OK;
              res.slot     = 4'(i);
            end
          end
        end
      end
      CMD_VALIDATE, CMD_DELETE: begin
        if (klen != KEY_BYTES) begin
          res.status = ST_BAD_LENGTH;
        end else begin
          for (int i = 0; i < limit; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == stored) hit = i;
          end
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.slot = 4'(hit);
            if (cmd == CMD_DELETE) begin
              drop_slot(hit);
            end else if (slot_expired(hit, now)) begin
              drop_slot(hit);
              res.status = ST_EXPIRED;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < limit; i++) begin
          if (tbl_valid[i] && slot_expired(i, now)) begin
            drop_slot(i);
            res.cleared++;
          end
        end
      end
    endcase
    res.live = 5'(tbl_live);
    return res;
  endfunction

  // Offers one command transaction, optionally after an idle burst, and
  // returns at the edge where it is accepted. Valid stays high on return,
  // so the next command can follow without valid dropping in between.
  task automatic send_command(cmd_e cmd, logic [63:0] key, logic [7:0] klen,
                              logic [31:0] life, logic [31:0] now);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    key_i          <= key;
    key_length_i   <= klen;
    lifetime_i     <= life;
    current_time_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_outcomes.push_back(table_outcome(cmd, key, klen, life, now));
  endtask

  // Stops offering commands and waits until every result has been taken
  // and the block has had time to settle.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // The slots-in-use register is written only while the block is idle.
  task automatic set_slot_limit(logic [4:0] value);
    wait_until_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    tbl_limit_reg = value;
  endtask

  task automatic refill_key_pool();
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
  endtask

  // One random command. Most are well formed: pool keys, the correct key
  // length outside creates, and short lifetimes on a slowly advancing clock,
  // so that sessions are created, found, deleted and age out. A few are pure noise.
  task automatic send_random_item();
    int unsigned pick;
    logic [63:0] key;
    logic [7:0]  klen;
    logic [31:0] life;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) wall_time = $urandom;
    else wall_time += $urandom_range(0, 3);
    key  = key_pool[$urandom_range(0, POOL_KEYS - 1)];
    klen = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(KEY_BYTES);
    life = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
    if (pick < 36) begin
      send_command(CMD_CREATE, key, 8'($urandom), life, wall_time);
    end else if (pick < 66) begin
      send_command(CMD_VALIDATE, key, klen, life, wall_time);
    end else if (pick < 86) begin
      send_command(CMD_DELETE, key, klen, life, wall_time);
    end else if (pick < 95) begin
      send_command(CMD_CLEANUP, key, klen, life, wall_time);
    end else begin
      send_command(cmd_e'($urandom_range(0, 3)), {$urandom, $urandom}, 8'($urandom),
                   32'($urandom), 32'($urandom));
    end
  endtask

  // Extremes of the fields and every command at the reset limit, including
  // the wrapped age of a session created just before the time counter wraps.
  task automatic test_directed_commands();
    send_command(CMD_CREATE, 64'd0, 8'd0, 32'd0, 32'd0);
    send_command(CMD_CREATE, {64{1'b1}}, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_VALIDATE, {64{1'b1}}, 8'(KEY_BYTES), 32'd0, 32'd5);
    send_command(CMD_VALIDATE, 64'd0, 8'(KEY_BYTES), 32'd0, 32'd0);
    // Zero lifetime: one time step later the session is expired and removed.
    send_command(CMD_VALIDATE, 64'd0, 8'(KEY_BYTES), 32'd0, 32'd1);
    send_command(CMD_VALIDATE, 64'd0, 8'(KEY_BYTES), 32'd0, 32'd1);
    send_command(CMD_VALIDATE, {64{1'b1}}, 8'(KEY_BYTES - 1), 32'd0, 32'd6);
    send_command(CMD_DELETE, {64{1'b1}}, 8'd0, 32'd0, 32'd6);
    send_command(CMD_DELETE, {64{1'b1}}, 8'(KEY_BYTES), 32'd0, 32'd6);
    send_command(CMD_DELETE, {64{1'b1}}, 8'(KEY_BYTES), 32'd0, 32'd6);
    send_command(CMD_CREATE, 64'h0123_4567_89AB_CDEF, 8'(KEY_BYTES), 32'd10,
                 32'hFFFF_FFF8);
    send_command(CMD_CREATE, 64'hFEDC_BA98_7654_3210, 8'(KEY_BYTES), 32'd20,
                 32'hFFFF_FFF8);
    send_command(CMD_CLEANUP, 64'd0, 8'd0, 32'd0, 32'd3);
    send_command(CMD_CLEANUP, 64'd0, 8'd0, 32'd0, 32'd13);
  endtask

  // Small, zero, saturated and lowered limits, with live slots left above
  // a lowered limit.
  task automatic test_slot_limits();
    set_slot_limit(5'd1);
    send_command(CMD_CREATE, 64'hA5A5_0000_0000_0001, 8'(KEY_BYTES), 32'd5, 32'd100);
    send_command(CMD_CREATE, 64'hA5A5_0000_0000_0002, 8'(KEY_BYTES), 32'd5, 32'd100);
    send_command(CMD_VALIDATE, 64'hA5A5_0000_0000_0002, 8'(KEY_BYTES), 32'd0, 32'd100);
    set_slot_limit(5'd0);
    send_command(CMD_CREATE, 64'hA5A5_0000_0000_0003, 8'(KEY_BYTES), 32'd5, 32'd100);
    send_command(CMD_VALIDATE, 64'hA5A5_0000_0000_0001, 8'(KEY_BYTES), 32'd0, 32'd100);
    send_command(CMD_CLEANUP, 64'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
    set_slot_limit(5'd31);
    for (int i = 0; i < 3; i++) begin
      send_command(CMD_CREATE, 64'h5A5A_0000_0000_0000 | 64'(i), 8'(KEY_BYTES),
                   32'hFFFF_FFFF, 32'd200);
    end
    set_slot_limit(5'd2);
    send_command(CMD_VALIDATE, 64'h5A5A_0000_0000_0002, 8'(KEY_BYTES), 32'd0, 32'd201);
    send_command(CMD_CREATE, 64'hA5A5_0000_0000_0004, 8'(KEY_BYTES), 32'd5, 32'd201);
    send_command(CMD_CLEANUP, 64'd0, 8'd0, 32'd0, 32'h8000_0000);
    set_slot_limit(5'd16);
    send_command(CMD_DELETE, 64'h5A5A_0000_0000_0002, 8'(KEY_BYTES), 32'd0, 32'd300);
  endtask

  // The result side holds off for a long stretch while commands keep
  // coming, so the block fills up and must stall its command input.
  task automatic test_result_backpressure();
    refill_key_pool();
    wall_time = 32'd1000;
    result_hold_cycles = RESULT_HOLD;
    repeat (24) send_random_item();
  endtask

  // Random traffic in phases at different limits. The last phase runs
  // without idle bursts on either side.
  task automatic test_random_traffic();
    logic [4:0]  limits [7] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd11, 5'd16};
    int unsigned counts [7] = '{140, 110, 130, 80, 30, 150, 160};
    for (int p = 0; p < 7; p++) begin
      if (p == 6) idle_en = 1'b0;
      set_slot_limit(limits[p]);
      refill_key_pool();
      repeat (counts[p]) send_random_item();
    end
  endtask

  // Result side: ready with random idle bursts, or a long hold-off when a
  // test asks for one.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (result_hold_cycles) @(posedge clk_i);
        result_hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every accepted result transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with none expected: status %0d slot %0d live %0d cleared %0d",
                   $realtime, status_o, slot_index_o, live_count_o, cleared_count_o);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status || slot_index_o !== want.slot ||
            live_count_o !== want.live || cleared_count_o !== want.cleared) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch status %0d/%0d slot %0d/%0d live %0d/%0d cleared %0d/%0d",
                     $realtime, want.status, status_o, want.slot, slot_index_o,
                     want.live, live_count_o, want.cleared, cleared_count_o);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("session_key_table_with_expiry regression: fail");
    $finish;
  end

  initial begin
    mismatch_count     = 0;
    idle_en            = 1'b1;
    result_hold_cycles = 0;
    wall_time          = '0;
    reset_table_model();
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    command_i      <= CMD_CREATE;
    key_i          <= '0;
    key_length_i   <= '0;
    lifetime_i     <= '0;
    current_time_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_commands();
    test_slot_limits();
    test_result_backpressure();
    test_random_traffic();

    wait_until_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("session_key_table_with_expiry regression: pass");
    end else begin
      $display("session_key_table_with_expiry regression: fail");
    end
    $finish;
  end

endmodule
